>>> src/tlrqs_pkg.sv
// Package of the three-level ready queue scheduler: request and result types and codes.
package tlrqs_pkg;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_RET  = 2'd2;
  localparam logic [1:0] OP_PICK = 2'd3;

  localparam logic [1:0] LVL_HIGH   = 2'd0;
  localparam logic [1:0] LVL_MEDIUM = 2'd1;
  localparam logic [1:0] LVL_LOW    = 2'd2;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_FULL   = 2'd1;
  localparam logic [1:0] ERR_NO_RUN = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] pid;
    logic [1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [7:0]  running_pid;
    logic        running_valid;
    logic        running_is_idle;
    logic [31:0] cycle_count;
    logic [4:0]  high_count;
    logic [4:0]  medium_count;
    logic [4:0]  low_count;
    logic [1:0]  error;
  } res_t;

endpackage

>>> src/three_level_ready_queue_scheduler.sv
// Top level of the three-level ready queue scheduler with its queue memory.
//
// Enqueue, run and return requests need no wait state: the result strobe out_valid
// comes in the cycle after the request is accepted, and a new request may be accepted
// in every cycle while busy is low, also while a result is on the output. A pick that
// finds a waiting process goes through the pick state, as the head entry is read
// from the queue memory, whose read data is registered; busy is high in that state. A
// pick with all queues empty runs the idle process at once. The receiver cannot
// stall: each result is shown for exactly one cycle. The queue memory needs no
// clearing pass after reset, so the block takes requests from the first cycle on.
module three_level_ready_queue_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_BITS    = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tlrqs_pkg::req_t   in_req,
  output logic              out_valid,
  output tlrqs_pkg::res_t   out_res,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);
  import tlrqs_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int ADDR_W = $clog2(3 * QUEUE_DEPTH);
  localparam logic [ADDR_W-1:0] BASE1 = ADDR_W'(QUEUE_DEPTH);
  localparam logic [ADDR_W-1:0] BASE2 = ADDR_W'(2 * QUEUE_DEPTH);

  typedef enum logic {ST_IDLE, ST_PICK} state_t;

  state_t              state_r, state_nxt;
  logic [7:0]          idle_pid_r;
  logic [IDX_W-1:0]    head_r [3];
  logic [IDX_W-1:0]    head_nxt [3];
  logic [FILL_W-1:0]   fill_r [3];
  logic [FILL_W-1:0]   fill_nxt [3];
  logic [PID_BITS-1:0] run_id_r, run_id_nxt;
  logic [1:0]          run_lvl_r, run_lvl_nxt;
  logic                present_r, present_nxt;
  logic                idle_flag_r, idle_flag_nxt;
  logic [31:0]         cycles_r, cycles_nxt;
  logic [1:0]          mod3_r, mod3_nxt;
  logic [2:0]          mod7_r, mod7_nxt;
  logic [1:0]          pick_lvl_r, pick_lvl_nxt;
  logic [1:0]          err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [PID_BITS-1:0] mem [3 * QUEUE_DEPTH];
  logic [PID_BITS-1:0] rd_data_r;
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [PID_BITS-1:0] wr_data;

  logic                accept;
  logic [1:0]          pri_c;
  logic [1:0]          start_lvl;
  logic [1:0]          sel_lvl;
  logic [IDX_W-1:0]    tail [3];
  logic [2:0]          full;
  logic [2:0]          ne;
  logic [SUM_W-1:0]    sum [3];

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] lvl,
                                                  input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] base;
    case (lvl)
      LVL_HIGH:   base = '0;
      LVL_MEDIUM: base = BASE1;
      default:    base = BASE2;
    endcase
    return base + ADDR_W'(idx);
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r == ST_PICK);
  assign pri_c  = (in_req.priority_req > LVL_LOW) ? LVL_LOW : in_req.priority_req;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i]  = SUM_W'(head_r[i]) + SUM_W'(fill_r[i]);
      tail[i] = (sum[i] >= SUM_W'(QUEUE_DEPTH)) ? IDX_W'(sum[i] - SUM_W'(QUEUE_DEPTH))
                                                 : IDX_W'(sum[i]);
      full[i] = (fill_r[i] == FILL_W'(QUEUE_DEPTH));
      ne[i]   = (fill_r[i] != '0);
    end
  end

  // Start level from the cycle count, then rotate past empty queues.
  always_comb begin
    if (mod3_r == 2'd0) begin
      start_lvl = LVL_MEDIUM;
    end else if (mod7_r == 3'd0) begin
      start_lvl = LVL_LOW;
    end else begin
      start_lvl = LVL_HIGH;
    end
    case (start_lvl)
      LVL_HIGH: begin
        sel_lvl = ne[0] ? LVL_HIGH : (ne[1] ? LVL_MEDIUM : LVL_LOW);
      end
      LVL_MEDIUM: begin
        sel_lvl = ne[1] ? LVL_MEDIUM : (ne[2] ? LVL_LOW : LVL_HIGH);
      end
      default: begin
        sel_lvl = ne[2] ? LVL_LOW : (ne[0] ? LVL_HIGH : LVL_MEDIUM);
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    run_id_nxt    = run_id_r;
    run_lvl_nxt   = run_lvl_r;
    present_nxt   = present_r;
    idle_flag_nxt = idle_flag_r;
    cycles_nxt    = cycles_r;
    mod3_nxt      = mod3_r;
    mod7_nxt      = mod7_r;
    pick_lvl_nxt  = pick_lvl_r;
    err_nxt       = err_r;
    out_valid_nxt = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = slot_addr(pri_c, tail[pri_c]);
    wr_data       = PID_BITS'(in_req.pid);
    rd_en         = 1'b0;
    rd_addr       = slot_addr(sel_lvl, head_r[sel_lvl]);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          err_nxt       = ERR_NONE;
          case (in_req.op)
            OP_ENQ: begin
              if (full[pri_c]) begin
                err_nxt = ERR_FULL;
              end else begin
                wr_en           = 1'b1;
                fill_nxt[pri_c] = fill_r[pri_c] + FILL_W'(1);
              end
            end
            OP_RUN: begin
              cycles_nxt = cycles_r + 32'd1;
              // The residues restart together with the counter when it wraps.
              if (cycles_nxt == 32'd0) begin
                mod3_nxt = 2'd0;
                mod7_nxt = 3'd0;
              end else begin
                mod3_nxt = (mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;
                mod7_nxt = (mod7_r == 3'd6) ? 3'd0 : mod7_r + 3'd1;
              end
            end
            OP_RET: begin
              wr_addr = slot_addr(run_lvl_r, tail[run_lvl_r]);
              wr_data = run_id_r;
              if (!present_r) begin
                err_nxt = ERR_NO_RUN;
              end else if (idle_flag_r) begin
                present_nxt   = 1'b0;
                idle_flag_nxt = 1'b0;
              end else if (full[run_lvl_r]) begin
                err_nxt = ERR_FULL;
              end else begin
                wr_en               = 1'b1;
                fill_nxt[run_lvl_r] = fill_r[run_lvl_r] + FILL_W'(1);
                present_nxt         = 1'b0;
              end
            end
            default: begin
              if (ne == 3'b000) begin
                run_id_nxt    = PID_BITS'(idle_pid_r);
                run_lvl_nxt   = LVL_HIGH;
                present_nxt   = 1'b1;
                idle_flag_nxt = 1'b1;
              end else begin
                // The head entry arrives from the memory in the next cycle.
                rd_en         = 1'b1;
                pick_lvl_nxt  = sel_lvl;
                state_nxt     = ST_PICK;
                out_valid_nxt = 1'b0;
              end
            end
          endcase
        end
      end
      default: begin
        run_id_nxt             = rd_data_r;
        run_lvl_nxt            = pick_lvl_r;
        present_nxt            = 1'b1;
        idle_flag_nxt          = 1'b0;
        head_nxt[pick_lvl_r]   = (head_r[pick_lvl_r] == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                 : head_r[pick_lvl_r] + IDX_W'(1);
        fill_nxt[pick_lvl_r]   = fill_r[pick_lvl_r] - FILL_W'(1);
        out_valid_nxt          = 1'b1;
        state_nxt              = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idle_pid_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
      run_id_r    <= '0;
      run_lvl_r   <= LVL_HIGH;
      present_r   <= 1'b0;
      idle_flag_r <= 1'b0;
      cycles_r    <= '0;
      mod3_r      <= '0;
      mod7_r      <= '0;
      pick_lvl_r  <= LVL_HIGH;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        idle_pid_r <= cfg_wdata;
      end
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      run_id_r    <= run_id_nxt;
      run_lvl_r   <= run_lvl_nxt;
      present_r   <= present_nxt;
      idle_flag_r <= idle_flag_nxt;
      cycles_r    <= cycles_nxt;
      mod3_r      <= mod3_nxt;
      mod7_r      <= mod7_nxt;
      pick_lvl_r  <= pick_lvl_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The state registers change at the edge that raises the strobe, so the result
  // is read straight from them.
  assign out_valid                = out_valid_r;
  assign out_res.running_pid      = present_r ? 8'(run_id_r) : 8'd0;
  assign out_res.running_valid    = present_r;
  assign out_res.running_is_idle  = present_r && idle_flag_r;
  assign out_res.cycle_count      = cycles_r;
  assign out_res.high_count       = 5'(fill_r[0]);
  assign out_res.medium_count     = 5'(fill_r[1]);
  assign out_res.low_count        = 5'(fill_r[2]);
  assign out_res.error            = err_r;

  a_busy_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $past(accept && in_req.op == OP_PICK))
    else $error("busy without a preceding pick request");

  a_strobe_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept || busy))
    else $error("result strobe without a request");

  a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid_r || busy))
    else $error("accepted request produced neither result nor memory read");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r[0] <= IDX_W'(QUEUE_DEPTH - 1)) && (head_r[1] <= IDX_W'(QUEUE_DEPTH - 1)) &&
    (head_r[2] <= IDX_W'(QUEUE_DEPTH - 1)))
    else $error("queue head beyond queue depth");

endmodule

>>> bench/three_level_ready_queue_scheduler_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the three-level ready queue scheduler.
module three_level_ready_queue_scheduler_test;
  import tlrqs_pkg::*;

  localparam int DEPTH         = 16;
  localparam int LEVELS        = 3;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;

  typedef enum logic [1:0] {ACT_REQ, ACT_PACE, ACT_DRAIN, ACT_CFG} action_kind_t;

  typedef struct {
    action_kind_t kind;
    req_t         req;
    int           value;
  } action_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  req_t       in_req    = '0;
  logic       out_valid;
  res_t       out_res;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;

  action_t script [$];
  res_t    sched_expected [$];
  int      outstanding  = 0;
  logic    feeding      = 1'b1;
  int      gap_pct      = 0;
  int      hold_off     = 0;
  int      quiet_cycles = 0;
  int      n_errors     = 0;

  // Shadow copy of the scheduler state.
  logic [7:0]  lane_ids [LEVELS][DEPTH];
  int          lane_head [LEVELS];
  int          lane_fill [LEVELS];
  logic [7:0]  cur_pid;
  logic [1:0]  cur_lane;
  logic        cur_valid;
  logic        cur_idle;
  logic [31:0] run_cycles;
  int          run_mod3;
  int          run_mod7;
  logic [7:0]  idle_id;

  three_level_ready_queue_scheduler #(
    .QUEUE_DEPTH(DEPTH),
    .PID_BITS(8)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit push_lane(logic [1:0] lvl, logic [7:0] id);
    if (lane_fill[lvl] >= DEPTH) return 1'b0;
    lane_ids[lvl][(lane_head[lvl] + lane_fill[lvl]) % DEPTH] = id;
    lane_fill[lvl]++;
    return 1'b1;
  endfunction

  function automatic res_t schedule_step(req_t r);
    logic [1:0] lvl;
    logic [1:0] err;
    res_t       res;
    lvl = (r.priority_req > LVL_LOW) ? LVL_LOW : r.priority_req;
    err = ERR_NONE;
    case (r.op)
      OP_ENQ: begin
        if (!push_lane(lvl, r.pid)) err = ERR_FULL;
      end
      OP_RUN: begin
        run_cycles = run_cycles + 32'd1;
        if (run_cycles == 32'd0) begin
          run_mod3 = 0;
          run_mod7 = 0;
        end else begin
          run_mod3 = (run_mod3 + 1) % 3;
          run_mod7 = (run_mod7 + 1) % 7;
        end
      end
      OP_RET: begin
        if (!cur_valid) begin
          err = ERR_NO_RUN;
        end else if (cur_idle) begin
          cur_valid = 1'b0;
          cur_idle  = 1'b0;
        end else if (push_lane(cur_lane, cur_pid)) begin
          cur_valid = 1'b0;
        end else begin
          err = ERR_FULL;
        end
      end
      default: begin
        if (lane_fill[LVL_HIGH] == 0 && lane_fill[LVL_MEDIUM] == 0 &&
            lane_fill[LVL_LOW] == 0) begin
          cur_pid   = idle_id;
          cur_lane  = LVL_HIGH;
          cur_valid = 1'b1;
          cur_idle  = 1'b1;
        end else begin
          if (run_mod3 == 0) lvl = LVL_MEDIUM;
          else if (run_mod7 == 0) lvl = LVL_LOW;
          else lvl = LVL_HIGH;
          // An empty level hands the choice on to the next one round the ring.
          repeat (LEVELS) if (lane_fill[lvl] == 0) lvl = (lvl == LVL_LOW) ? LVL_HIGH : lvl + 2'd1;
          cur_pid        = lane_ids[lvl][lane_head[lvl]];
          lane_head[lvl] = (lane_head[lvl] + 1) % DEPTH;
          lane_fill[lvl]--;
          cur_lane  = lvl;
          cur_valid = 1'b1;
          cur_idle  = 1'b0;
        end
      end
    endcase
    res.running_pid     = cur_valid ? cur_pid : 8'd0;
    res.running_valid   = cur_valid;
    res.running_is_idle = cur_valid && cur_idle;
    res.cycle_count     = run_cycles;
    res.high_count      = 5'(lane_fill[LVL_HIGH]);
    res.medium_count    = 5'(lane_fill[LVL_MEDIUM]);
    res.low_count       = 5'(lane_fill[LVL_LOW]);
    res.error           = err;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  task automatic add_req(logic [1:0] op, logic [7:0] pid, logic [1:0] pri);
    action_t a;
    a.kind             = ACT_REQ;
    a.req.op           = op;
    a.req.pid          = pid;
    a.req.priority_req = pri;
    a.value            = 0;
    script.push_back(a);
  endtask

  task automatic add_action(action_kind_t kind, int value);
    action_t a;
    a.kind  = kind;
    a.req   = '0;
    a.value = value;
    script.push_back(a);
  endtask

  // Segments draw sparse, balanced or heavy enqueueing at random, so that the
  // queues swing between empty (idle picks) and full (rejected requests).
  task automatic add_random_mix(int n);
    int left;
    int seg;
    int enq_pct;
    int fav;
    left = n;
    while (left > 0) begin
      seg = $urandom_range(50, 10);
      if (seg > left) seg = left;
      case ($urandom_range(2))
        0: enq_pct = 10;
        1: enq_pct = 35;
        default: enq_pct = 65;
      endcase
      fav = $urandom_range(3);
      repeat (seg) begin
        if ($urandom_range(99) < enq_pct) begin
          add_req(OP_ENQ, 8'($urandom),
                  ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'(fav));
        end else begin
          case ($urandom_range(2))
            0: add_req(OP_RUN, 8'($urandom), 2'($urandom));
            1: add_req(OP_RET, 8'($urandom), 2'($urandom));
            default: add_req(OP_PICK, 8'($urandom), 2'($urandom));
          endcase
        end
      end
      left -= seg;
    end
  endtask

  // Driver: takes the next action from the script once the previous request is gone.
  always @(posedge clk) begin
    logic n_start;
    logic n_we;
    n_start = 1'b0;
    n_we    = 1'b0;
    if (!rst_n) begin
      in_req    <= '0;
      cfg_wdata <= '0;
      hold_off  <= 0;
      gap_pct   <= 0;
    end else if (start && busy) begin
      n_start = 1'b1;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
    end else if (script.size() != 0) begin
      case (script[0].kind)
        ACT_REQ: begin
          if ($urandom_range(99) >= gap_pct) begin
            n_start = 1'b1;
            in_req <= script[0].req;
            void'(script.pop_front());
          end
        end
        ACT_PACE: begin
          gap_pct <= script[0].value;
          void'(script.pop_front());
        end
        ACT_DRAIN: begin
          if (!start && outstanding == 0) begin
            hold_off <= SETTLE_CYCLES;
            void'(script.pop_front());
          end
        end
        ACT_CFG: begin
          if (!start && outstanding == 0) begin
            n_we = 1'b1;
            cfg_wdata <= 8'(script[0].value);
            void'(script.pop_front());
          end
        end
        default: ;
      endcase
    end
    start   <= n_start;
    cfg_we  <= n_we;
    feeding <= !rst_n || n_start || script.size() != 0;
  end

  // Monitor: predicts each accepted request and checks each result strobe.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      foreach (lane_head[l]) begin
        lane_head[l] = 0;
        lane_fill[l] = 0;
      end
      cur_pid    = '0;
      cur_lane   = LVL_HIGH;
      cur_valid  = 1'b0;
      cur_idle   = 1'b0;
      run_cycles = '0;
      run_mod3   = 0;
      run_mod7   = 0;
      idle_id    = '0;
      sched_expected.delete();
    end else begin
      if (cfg_we) idle_id = cfg_wdata;
      if (start && !busy) sched_expected.push_back(schedule_step(in_req));
      if (out_valid) begin
        if (sched_expected.size() == 0) begin
          $error("result strobe with no request waiting");
          n_errors++;
        end else begin
          want = sched_expected.pop_front();
          check_field("running_pid", want.running_pid, out_res.running_pid);
          check_field("running_valid", want.running_valid, out_res.running_valid);
          check_field("running_is_idle", want.running_is_idle, out_res.running_is_idle);
          check_field("cycle_count", want.cycle_count, out_res.cycle_count);
          check_field("high_count", want.high_count, out_res.high_count);
          check_field("medium_count", want.medium_count, out_res.medium_count);
          check_field("low_count", want.low_count, out_res.low_count);
          check_field("error", want.error, out_res.error);
        end
      end
    end
    outstanding <= sched_expected.size();
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    add_action(ACT_CFG, 255);
    add_req(OP_RET, 8'h00, LVL_HIGH);
    add_req(OP_RUN, 8'hFF, 2'd3);
    add_req(OP_PICK, 8'h00, LVL_HIGH);
    add_req(OP_RET, 8'h00, LVL_HIGH);
    add_req(OP_ENQ, 8'h00, LVL_HIGH);
    add_req(OP_ENQ, 8'hFF, LVL_MEDIUM);
    add_req(OP_ENQ, 8'h5A, LVL_LOW);
    // A priority of three is taken as low.
    add_req(OP_ENQ, 8'hA5, 2'd3);
    add_req(OP_PICK, 8'h00, LVL_HIGH);
    // Picking over a running process drops it.
    add_req(OP_PICK, 8'h00, LVL_HIGH);
    add_req(OP_RET, 8'h00, LVL_HIGH);
    repeat (2) add_req(OP_RUN, 8'h00, LVL_HIGH);
    add_req(OP_PICK, 8'h00, LVL_HIGH);
    repeat (4) add_req(OP_RUN, 8'h00, LVL_HIGH);
    add_req(OP_PICK, 8'h00, LVL_HIGH);
    add_req(OP_RET, 8'h00, LVL_HIGH);
    repeat (3) add_req(OP_PICK, 8'h00, LVL_HIGH);
    add_req(OP_RUN, 8'h00, LVL_HIGH);
    add_random_mix(240);

    add_action(ACT_DRAIN, 0);
    add_action(ACT_CFG, 0);
    add_action(ACT_PACE, 71);
    add_random_mix(240);

    add_action(ACT_DRAIN, 0);
    add_action(ACT_CFG, $urandom_range(254, 1));
    add_action(ACT_PACE, 0);
    add_random_mix(230);

    add_action(ACT_DRAIN, 0);
    add_action(ACT_CFG, $urandom_range(255));
    add_action(ACT_PACE, 37);
    add_random_mix(240);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (feeding || start || outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sched_expected.size() != 0) begin
      $error("%0d results never arrived", sched_expected.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/tlrqs_pkg.sv
src/three_level_ready_queue_scheduler.sv
bench/three_level_ready_queue_scheduler_test.sv
